// ===== hw/rtl/vspt_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel simple-point thinning step package
// Shared types, neighborhood tables and helper functions.
// ----------------------------------------------------------------------------
package vspt_pkg;

  localparam int unsigned VALUE_BITS  = 14;
  localparam int unsigned NBR_BITS    = 26;
  localparam int unsigned POS_COUNT   = 27;
  localparam int unsigned CENTER_POS  = 13;
  localparam int unsigned GROW_STEPS  = 7;
  localparam int unsigned GROW_STAGES = 4;
  localparam int unsigned SIDE_BITS   = 3;
  localparam int unsigned ADDR_BITS   = 4;
  localparam int unsigned DATA_BITS   = 32;
  localparam logic [VALUE_BITS-1:0] PASS_LEVEL_RESET = VALUE_BITS'(2);

  typedef logic [POS_COUNT-1:0] pos_t;
  typedef logic [POS_COUNT-1:0][POS_COUNT-1:0] near_tab_t;

  typedef enum logic [1:0] {
    RegBorderSide = 2'd0,
    RegPassLevel  = 2'd1,
    RegKeepLast   = 2'd2,
    RegUnused     = 2'd3
  } cfg_reg_e;

  typedef enum logic [SIDE_BITS-1:0] {
    SideNegX = 3'd0,
    SidePosX = 3'd1,
    SideNegY = 3'd2,
    SidePosY = 3'd3,
    SideNegZ = 3'd4,
    SidePosZ = 3'd5
  } side_e;

  typedef struct packed {
    logic [VALUE_BITS-1:0] center_value;
    logic [NBR_BITS-1:0]   neighbour_bits;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] new_value;
    logic                  removed;
    logic                  on_border;
  } out_t;

  typedef struct packed {
    logic [SIDE_BITS-1:0]  border_side;
    logic [VALUE_BITS-1:0] pass_level;
    logic                  keep_last_point;
  } cfg_t;

  typedef struct packed {
    logic                  border;
    logic                  keep_last_hit;
    logic [VALUE_BITS-1:0] value;
    pos_t                  black;
    pos_t                  white;
    pos_t                  reach_b;
    pos_t                  reach_w;
  } stage_t;

  function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic near_tab_t build_near(bit six);
    near_tab_t   tab;
    int unsigned dx;
    int unsigned dy;
    int unsigned dz;
    tab = '0;
    for (int unsigned p = 0; p < POS_COUNT; p++) begin
      for (int unsigned q = 0; q < POS_COUNT; q++) begin
        dx = abs_diff(q % 3, p % 3);
        dy = abs_diff((q / 3) % 3, (p / 3) % 3);
        dz = abs_diff(q / 9, p / 9);
        if (q != p && q != CENTER_POS && p != CENTER_POS) begin
          if (six) begin
            tab[p][q] = (dx + dy + dz == 1);
          end else begin
            tab[p][q] = (dx <= 1 && dy <= 1 && dz <= 1);
          end
        end
      end
    end
    return tab;
  endfunction

  function automatic pos_t build_corner();
    pos_t m;
    m = '0;
    for (int unsigned p = 0; p < POS_COUNT; p++) begin
      m[p] = (p % 3 != 1) && ((p / 3) % 3 != 1) && (p / 9 != 1);
    end
    return m;
  endfunction

  localparam near_tab_t NEAR26      = build_near(1'b0);
  localparam near_tab_t NEAR6       = build_near(1'b1);
  localparam pos_t      CORNER_MASK = build_corner();
  localparam pos_t      CENTER_MASK = pos_t'(1) << CENTER_POS;
  localparam pos_t      SIX_MASK    = (pos_t'(1) << 4) | (pos_t'(1) << 10) | (pos_t'(1) << 12)
                                    | (pos_t'(1) << 14) | (pos_t'(1) << 16) | (pos_t'(1) << 22);

  // One dilation step of a region, limited to the given set.
  function automatic pos_t grow_once(pos_t reach, pos_t set, near_tab_t tab);
    pos_t nxt;
    nxt = reach;
    for (int unsigned q = 0; q < POS_COUNT; q++) begin
      nxt[q] = reach[q] | (set[q] & (|(reach & tab[q])));
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/voxel_simple_point_thinning_step_unit.sv =====
// ----------------------------------------------------------------------------
// Voxel simple-point thinning step unit
// Per-voxel keep or remove decision of one directional 3D thinning subpass.
// ----------------------------------------------------------------------------
// The unit takes one voxel with its 26 neighbor bits in every cycle while
// the output is not stalled, and returns one result beat per voxel. Most
// of the pipeline is the region growing that counts black and white
// components: 28 dilation steps split over the grow stages, with stage
// registers between an input register and an output register. A stall on
// the output holds the whole pipeline.
module voxel_simple_point_thinning_step_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vspt_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vspt_pkg::out_t                      out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vspt_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [vspt_pkg::DATA_BITS-1:0]      pwdata,
  output logic [vspt_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);
  import vspt_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e reg_sel;
  logic     cfg_write;

  logic     advance;
  logic     in_valid_q;
  in_t      in_q;
  logic     stage_valid_q [GROW_STAGES-1];
  stage_t   stage_q       [GROW_STAGES-1];
  stage_t   front_stage;
  stage_t   grow_out      [GROW_STAGES];
  logic     out_valid_q;
  out_t     out_q;
  out_t     result;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_e'(paddr[ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_sel)
      RegBorderSide: begin
        prdata = DATA_BITS'(cfg_q.border_side);
        if (cfg_write) begin
          cfg_d.border_side = pwdata[SIDE_BITS-1:0];
        end
      end
      RegPassLevel: begin
        prdata = DATA_BITS'(cfg_q.pass_level);
        if (cfg_write) begin
          cfg_d.pass_level = pwdata[VALUE_BITS-1:0];
        end
      end
      RegKeepLast: begin
        prdata = DATA_BITS'(cfg_q.keep_last_point);
        if (cfg_write) begin
          cfg_d.keep_last_point = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.border_side     <= SideNegX;
      cfg_q.pass_level      <= PASS_LEVEL_RESET;
      cfg_q.keep_last_point <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  vspt_front u_front (
    .in_data_i (in_q),
    .cfg_i     (cfg_q),
    .stage_o   (front_stage)
  );

  for (genvar g = 0; g < GROW_STAGES; g++) begin : g_grow
    if (g == 0) begin : g_first
      vspt_grow u_grow (
        .stage_i (front_stage),
        .stage_o (grow_out[g])
      );
    end else begin : g_next
      vspt_grow u_grow (
        .stage_i (stage_q[g-1]),
        .stage_o (grow_out[g])
      );
    end
  end

  vspt_decide u_decide (
    .stage_i (grow_out[GROW_STAGES-1]),
    .cfg_i   (cfg_q),
    .out_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int unsigned s = 0; s < GROW_STAGES - 1; s++) begin
        stage_valid_q[s] <= 1'b0;
      end
    end else if (advance) begin
      in_valid_q       <= in_valid_i;
      stage_valid_q[0] <= in_valid_q;
      for (int unsigned s = 1; s < GROW_STAGES - 1; s++) begin
        stage_valid_q[s] <= stage_valid_q[s-1];
      end
      out_valid_q <= stage_valid_q[GROW_STAGES-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_q <= in_data_i;
      for (int unsigned s = 0; s < GROW_STAGES - 1; s++) begin
        stage_q[s] <= grow_out[s];
      end
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.removed |-> out_data_o.on_border && out_data_o.new_value == '0)
    else $error("removed voxel must be a border voxel with value zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.on_border |-> !out_data_o.removed)
    else $error("non-border voxel reported as removed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stage_valid_q[GROW_STAGES-2]) && $past(advance))
    else $error("result beat appeared without a voxel in the last stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled while the output is free");

endmodule

// ===== hw/rtl/vspt_front.sv =====
// ----------------------------------------------------------------------------
// Voxel simple-point thinning front end
// Border test, black and white neighbor sets and region seeds for one voxel.
// ----------------------------------------------------------------------------
module vspt_front (
  input  vspt_pkg::in_t    in_data_i,
  input  vspt_pkg::cfg_t   cfg_i,
  output vspt_pkg::stage_t stage_o
);
  import vspt_pkg::*;

  logic [NBR_BITS-1:0] bits;
  logic                side_bit;
  logic                side_ok;
  pos_t                black;
  pos_t                white;
  pos_t                white_seeds;

  assign bits = in_data_i.neighbour_bits;

  always_comb begin
    side_ok  = 1'b1;
    side_bit = 1'b0;
    case (cfg_i.border_side)
      SideNegX: side_bit = bits[12];
      SidePosX: side_bit = bits[13];
      SideNegY: side_bit = bits[10];
      SidePosY: side_bit = bits[15];
      SideNegZ: side_bit = bits[4];
      SidePosZ: side_bit = bits[21];
      default:  side_ok  = 1'b0;
    endcase
  end

  always_comb begin
    black = '0;
    for (int unsigned p = 0; p < POS_COUNT; p++) begin
      if (p < CENTER_POS) begin
        black[p] = bits[p];
      end else if (p > CENTER_POS) begin
        black[p] = bits[p-1];
      end
    end
  end

  assign white       = ~black & ~CORNER_MASK & ~CENTER_MASK;
  assign white_seeds = white & SIX_MASK;

  always_comb begin
    stage_o.border        = (in_data_i.center_value != '0) && side_ok && !side_bit;
    stage_o.keep_last_hit = cfg_i.keep_last_point && (bits != '0)
                            && ((bits & (bits - NBR_BITS'(1))) == '0);
    stage_o.value         = in_data_i.center_value;
    stage_o.black         = black;
    stage_o.white         = white;
    stage_o.reach_b       = black & (~black + pos_t'(1));
    stage_o.reach_w       = white_seeds & (~white_seeds + pos_t'(1));
  end

endmodule

// ===== hw/rtl/vspt_grow.sv =====
// ----------------------------------------------------------------------------
// Voxel simple-point thinning region grower
// A fixed number of dilation steps for the black and the white region.
// ----------------------------------------------------------------------------
module vspt_grow (
  input  vspt_pkg::stage_t stage_i,
  output vspt_pkg::stage_t stage_o
);
  import vspt_pkg::*;

  pos_t reach_b;
  pos_t reach_w;

  always_comb begin
    reach_b = stage_i.reach_b;
    reach_w = stage_i.reach_w;
    for (int unsigned k = 0; k < GROW_STEPS; k++) begin
      reach_b = grow_once(reach_b, stage_i.black, NEAR26);
      reach_w = grow_once(reach_w, stage_i.white, NEAR6);
    end
    stage_o         = stage_i;
    stage_o.reach_b = reach_b;
    stage_o.reach_w = reach_w;
  end

endmodule

// ===== hw/rtl/vspt_decide.sv =====
// ----------------------------------------------------------------------------
// Voxel simple-point thinning decision
// Keeps or removes a border voxel from its grown regions.
// ----------------------------------------------------------------------------
module vspt_decide (
  input  vspt_pkg::stage_t stage_i,
  input  vspt_pkg::cfg_t   cfg_i,
  output vspt_pkg::out_t   out_o
);
  import vspt_pkg::*;

  logic black_multi;
  logic black_any;
  logic white_multi;
  logic keep;

  assign black_multi = |(stage_i.black & ~stage_i.reach_b);
  assign black_any   = |stage_i.black;
  assign white_multi = |(stage_i.white & SIX_MASK & ~stage_i.reach_w);
  assign keep        = black_multi || stage_i.keep_last_hit || (black_any && white_multi);

  always_comb begin
    out_o.new_value = stage_i.value;
    out_o.removed   = 1'b0;
    out_o.on_border = stage_i.border;
    if (stage_i.border) begin
      if (keep) begin
        if (stage_i.value == VALUE_BITS'(1)) begin
          out_o.new_value = cfg_i.pass_level;
        end
      end else begin
        out_o.new_value = '0;
        out_o.removed   = 1'b1;
      end
    end
  end

endmodule

// ===== test/voxel_simple_point_thinning_step_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Voxel simple-point thinning step unit testbench
// Streams voxel neighborhoods through the unit under several register
// settings and handshake patterns. Every result beat is checked field by
// field against a fixed table entry or a local model of the border,
// black-component and white-tunnel decision.
// ----------------------------------------------------------------------------
module voxel_simple_point_thinning_step_unit_tb;

  import vspt_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 20;
  localparam bit [26:0] FACE_SEEDS = (27'd1 << 4) | (27'd1 << 10) | (27'd1 << 12)
                                   | (27'd1 << 14) | (27'd1 << 16) | (27'd1 << 22);

  typedef struct packed {
    logic [VALUE_BITS-1:0] center;
    logic [NBR_BITS-1:0]   nbrs;
    bit                    typed;
    logic [VALUE_BITS-1:0] new_value;
    logic                  removed;
    logic                  on_border;
  } voxel_row_t;

  typedef struct {
    logic [31:0] side_word;
    logic [31:0] level_word;
    logic [31:0] keep_word;
    int          send_pct;
    int          recv_pct;
    int          beats;
    bit          long_hold;
    bit          mid_pause;
  } phase_t;

  localparam voxel_row_t VOXEL_ROWS [15] = '{
    '{14'h0000, 26'h0000000, 1'b1, 14'h0000, 1'b0, 1'b0},
    '{14'h0000, 26'h3ffffff, 1'b1, 14'h0000, 1'b0, 1'b0},
    '{14'h3fff, 26'h0001000, 1'b1, 14'h3fff, 1'b0, 1'b0},
    '{14'h3fff, 26'h3ffffff, 1'b1, 14'h3fff, 1'b0, 1'b0},
    '{14'h0005, 26'h0000000, 1'b1, 14'h0000, 1'b1, 1'b1},
    '{14'h0001, 26'h0000000, 1'b1, 14'h0000, 1'b1, 1'b1},
    '{14'h3fff, 26'h0000000, 1'b1, 14'h0000, 1'b1, 1'b1},
    '{14'h0001, 26'h3ffefff, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h0001, 26'h0002000, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h0001, 26'h0002001, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h0007, 26'h2000001, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h0002, 26'h2aaaaaa, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h0001, 26'h1555555, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h3fff, 26'h001ee00, 1'b0, 14'h0000, 1'b0, 1'b0},
    '{14'h0001, 26'h0200010, 1'b0, 14'h0000, 1'b0, 1'b0}
  };

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [ADDR_BITS-1:0] paddr   = '0;
  logic [DATA_BITS-1:0] pwdata  = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  logic [SIDE_BITS-1:0]  cfg_side      = 3'd0;
  logic [VALUE_BITS-1:0] cfg_level     = PASS_LEVEL_RESET;
  logic                  cfg_keep_last = 1'b0;

  bit [26:0] touch26 [27];
  bit [26:0] touch6  [27];

  out_t   pending_results [$];
  int     mismatch_count = 0;
  int     send_pct = 0;
  int     recv_pct = 0;
  bit     hold_request = 1'b0;
  int     hold_left = 0;
  int     quiet_cycles = 0;
  phase_t phases [7];

  voxel_simple_point_thinning_step_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic fill_adjacency();
    int dx;
    int dy;
    int dz;
    for (int p = 0; p < 27; p++) begin
      touch26[p] = '0;
      touch6[p]  = '0;
      for (int q = 0; q < 27; q++) begin
        dx = (q % 3) - (p % 3);
        dy = ((q / 3) % 3) - ((p / 3) % 3);
        dz = (q / 9) - (p / 9);
        dx = dx < 0 ? -dx : dx;
        dy = dy < 0 ? -dy : dy;
        dz = dz < 0 ? -dz : dz;
        if (q != p && q != CENTER_POS && p != CENTER_POS) begin
          touch26[p][q] = (dx <= 1 && dy <= 1 && dz <= 1);
          touch6[p][q]  = (dx + dy + dz == 1);
        end
      end
    end
  endtask

  function automatic int facing_bit(logic [SIDE_BITS-1:0] side);
    case (side_e'(side))
      SideNegX: return 12;
      SidePosX: return 13;
      SideNegY: return 10;
      SidePosY: return 15;
      SideNegZ: return 4;
      SidePosZ: return 21;
      default:  return -1;
    endcase
  endfunction

  function automatic int count_components(bit [26:0] set, bit [26:0] seeds, bit six);
    bit [26:0] rest;
    bit [26:0] part;
    bit [26:0] prev;
    int        n;
    rest = set;
    n    = 0;
    for (int q = 0; q < 27; q++) begin
      if (rest[q] && seeds[q]) begin
        part    = '0;
        part[q] = 1'b1;
        do begin
          prev = part;
          for (int r = 0; r < 27; r++) begin
            if (part[r]) begin
              part |= (six ? touch6[r] : touch26[r]) & set;
            end
          end
        end while (part != prev);
        rest &= ~part;
        n++;
      end
    end
    return n;
  endfunction

  function automatic out_t decide_voxel(in_t beat);
    out_t      res;
    bit [26:0] black;
    bit [26:0] white;
    int        nblack;
    int        parts;
    int        b;
    bit        keep;
    res.new_value = beat.center_value;
    res.removed   = 1'b0;
    res.on_border = 1'b0;
    if (beat.center_value == '0 || cfg_side > SideNegZ + 1 ||
        beat.neighbour_bits[facing_bit(cfg_side)]) begin
      return res;
    end
    res.on_border = 1'b1;
    black  = '0;
    white  = '0;
    nblack = 0;
    for (int p = 0; p < 27; p++) begin
      if (p != CENTER_POS) begin
        b = p < CENTER_POS ? p : p - 1;
        if (beat.neighbour_bits[b]) begin
          black[p] = 1'b1;
          nblack++;
        end else if (!((p % 3) != 1 && ((p / 3) % 3) != 1 && (p / 9) != 1)) begin
          white[p] = 1'b1;
        end
      end
    end
    parts = count_components(black, black, 1'b0);
    keep  = (parts > 1) || (cfg_keep_last && nblack == 1) ||
            (parts == 1 && count_components(white, FACE_SEEDS, 1'b1) > 1);
    if (keep) begin
      res.new_value = (beat.center_value == VALUE_BITS'(1)) ? cfg_level : beat.center_value;
    end else begin
      res.new_value = '0;
      res.removed   = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [NBR_BITS-1:0] scatter_bits(int pct);
    logic [NBR_BITS-1:0] bits;
    for (int i = 0; i < NBR_BITS; i++) begin
      bits[i] = ($urandom_range(0, 99) < pct);
    end
    return bits;
  endfunction

  function automatic in_t random_voxel();
    in_t beat;
    int  pos;
    case ($urandom_range(0, 9))
      0:       beat.neighbour_bits = NBR_BITS'($urandom);
      1:       beat.neighbour_bits = '0;
      2:       beat.neighbour_bits = NBR_BITS'(1) << $urandom_range(0, NBR_BITS - 1);
      3, 4:    beat.neighbour_bits = scatter_bits(15);
      5, 6:    beat.neighbour_bits = scatter_bits(50);
      7, 8:    beat.neighbour_bits = scatter_bits(80);
      default: beat.neighbour_bits = scatter_bits(95);
    endcase
    case ($urandom_range(0, 9))
      0:          beat.center_value = '0;
      1, 2, 3:    beat.center_value = VALUE_BITS'(1);
      4:          beat.center_value = '1;
      default:    beat.center_value = VALUE_BITS'($urandom);
    endcase
    pos = facing_bit(cfg_side);
    if (pos >= 0 && $urandom_range(0, 9) < 7) begin
      beat.neighbour_bits[pos] = 1'b0;
    end
    return beat;
  endfunction

  task automatic send_voxel(in_t beat, bit typed, out_t typed_res);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < send_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= beat;
        placed = 1'b1;
      end
    end
    do @(posedge clk_i); while (in_stall);
    pending_results.push_back(typed ? typed_res : decide_voxel(beat));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegBorderSide: cfg_side      = value[SIDE_BITS-1:0];
      RegPassLevel:  cfg_level     = value[VALUE_BITS-1:0];
      RegKeepLast:   cfg_keep_last = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no voxel outstanding: new_value %0h", out_data.new_value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.new_value !== want.new_value) begin
          $error("new_value: expected %0h, got %0h", want.new_value, out_data.new_value);
          mismatch_count++;
        end
        if (out_data.removed !== want.removed) begin
          $error("removed: expected %0b, got %0b", want.removed, out_data.removed);
          mismatch_count++;
        end
        if (out_data.on_border !== want.on_border) begin
          $error("on_border: expected %0b, got %0b", want.on_border, out_data.on_border);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    voxel_row_t row;
    phase_t     ph;
    in_t        beat;
    phases[0] = '{32'h0000_0001, 32'h0000_3fff, 32'h0000_0001, 0, 0, 170, 1'b0, 1'b0};
    phases[1] = '{32'hffff_fffe, 32'h0000_0000, 32'h0000_0000, 86, 0, 60, 1'b0, 1'b0};
    phases[2] = '{32'h0000_0007, 32'h0000_0001, 32'h0000_0000, 0, 86, 40, 1'b0, 1'b0};
    phases[3] = '{32'h0000_0002, 32'hffff_c000, 32'hffff_ffff, 8, 8, 120, 1'b1, 1'b0};
    phases[4] = '{32'h0000_0003, 32'h0000_0064, 32'h0000_0000, 0, 86, 120, 1'b0, 1'b0};
    phases[5] = '{32'h0000_0004, 32'hdead_4002, 32'h0000_0001, 86, 0, 120, 1'b0, 1'b0};
    phases[6] = '{32'h0000_0005, 32'h0000_2345, 32'h0000_0000, 8, 8, 150, 1'b0, 1'b1};
    fill_adjacency();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (VOXEL_ROWS[i]) begin
      row = VOXEL_ROWS[i];
      beat.center_value   = row.center;
      beat.neighbour_bits = row.nbrs;
      send_voxel(beat, row.typed, {row.new_value, row.removed, row.on_border});
    end
    stop_sending();
    wait_for_results();

    foreach (phases[i]) begin
      ph = phases[i];
      write_register(RegBorderSide, ph.side_word);
      write_register(RegPassLevel, ph.level_word);
      write_register(RegKeepLast, ph.keep_word);
      send_pct = ph.send_pct;
      recv_pct = ph.recv_pct;
      for (int k = 0; k < ph.beats; k++) begin
        if (ph.long_hold && k == 30) begin
          hold_request = 1'b1;
        end
        if (ph.mid_pause && k == ph.beats / 2) begin
          stop_sending();
          wait_for_results();
        end
        send_voxel(random_voxel(), 1'b0, '0);
      end
      stop_sending();
      wait_for_results();
    end

    send_pct = 0;
    recv_pct = 0;
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
